// ===== hdl/assert_macros.svh =====
// Assertion macros for the RTL of the flood detector.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_SAME_CYCLE(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

`define ASSERT_NEXT_CYCLE(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define ASSERT_SAME_CYCLE(lbl, clk, rst_n, ante, cons)

`define ASSERT_NEXT_CYCLE(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== hdl/dfd_pkg.sv =====
// Package with codes, widths and reset values of the deauth flood detector.
`timescale 1ns / 1ps

package dfd_pkg;

    localparam int TIME_W    = 63;
    localparam int MAC_W     = 48;
    localparam int COUNT_W   = 32;
    localparam int THRESH_W  = 16;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [1:0] FTYPE_MGMT       = 2'd0;
    localparam logic [3:0] SUBTYPE_DEAUTH   = 4'hC;
    localparam logic [3:0] SUBTYPE_DISASSOC = 4'hA;

    localparam logic REQ_FRAME = 1'b0;
    localparam logic REQ_POLL  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_FLOOD_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_QUIET_TIME      = 2'd2;

    localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 16'd6;
    localparam logic [CFG_W-1:0]    WINDOW_RESET    = 32'd1000000;
    localparam logic [CFG_W-1:0]    QUIET_RESET     = 32'd3000000;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef struct packed {
        logic              req_type;
        logic [TIME_W-1:0] now_us;
        logic [1:0]        frame_type;
        logic [3:0]        frame_subtype;
        logic [MAC_W-1:0]  source_mac;
    } dfd_item_t;

endpackage

// ===== hdl/deauth_flood_detector_unit.sv =====
// Top level of the deauth/disassoc flood detector: input stage, state update and result.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// An accepted beat is registered in the input stage, then its result in the detector state.
// Throughput: one beat per cycle unless the output stalls; the window, alert and totals update in one pass.
// The input side stalls only while the input stage is full and a finished result is stalled.
// Reset (rst_n low, asynchronous) clears all statistics and flags and loads the register
// defaults: threshold 6, window 1000000 us, quiet time 3000000 us.
module deauth_flood_detector_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write_en,
    input  logic [dfd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dfd_pkg::CFG_W-1:0]          cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               req_type,
    input  logic [dfd_pkg::TIME_W-1:0]         now_us,
    input  logic [1:0]                         frame_type,
    input  logic [3:0]                         frame_subtype,
    input  logic [dfd_pkg::MAC_W-1:0]          source_mac,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [dfd_pkg::COUNT_W-1:0]        deauth_tally,
    output logic [dfd_pkg::COUNT_W-1:0]        disassoc_tally,
    output logic                               alert_active,
    output logic [dfd_pkg::MAC_W-1:0]          alert_source,
    output logic [dfd_pkg::COUNT_W-1:0]        alert_count
);
    import dfd_pkg::*;

    // Configuration registers.
    logic [THRESH_W-1:0] threshold_reg;
    logic [CFG_W-1:0]    window_len_reg;
    logic [CFG_W-1:0]    quiet_time_reg;

    // Input stage.
    logic      stage_valid_reg;
    dfd_item_t stage_reg;

    // Detector state; it also serves as the result register.
    logic [COUNT_W-1:0]  deauth_cnt_reg,     deauth_cnt_next;
    logic [COUNT_W-1:0]  disassoc_cnt_reg,   disassoc_cnt_next;
    logic                window_open_reg,    window_open_next;
    logic [TIME_W-1:0]   window_start_reg,   window_start_next;
    logic [COUNT_W-1:0]  window_frames_reg,  window_frames_next;
    logic [MAC_W-1:0]    window_source_reg,  window_source_next;
    logic                alert_flag_reg,     alert_flag_next;
    logic [MAC_W-1:0]    alert_mac_reg,      alert_mac_next;
    logic [COUNT_W-1:0]  alert_rate_reg,     alert_rate_next;
    logic                flood_seen_reg,     flood_seen_next;
    logic [TIME_W-1:0]   last_flood_reg,     last_flood_next;
    logic                out_valid_reg;

    logic               advance;
    logic               counted;
    logic               is_deauth;
    logic [TIME_W-1:0]  since_start;
    logic [TIME_W-1:0]  since_flood;
    logic               expired;
    logic               quiet;
    logic               new_window;
    logic [COUNT_W-1:0] frames_base;
    logic [COUNT_W-1:0] frames_inc;

    // The stage moves on unless a finished result is still waiting downstream.
    assign advance  = stage_valid_reg && !(out_valid_reg && out_stall);
    assign in_stall = stage_valid_reg && out_valid_reg && out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg  <= THRESHOLD_RESET;
            window_len_reg <= WINDOW_RESET;
            quiet_time_reg <= QUIET_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_FLOOD_THRESHOLD: threshold_reg  <= cfg_data[THRESH_W-1:0];
                REG_WINDOW_LENGTH:   window_len_reg <= cfg_data;
                REG_QUIET_TIME:      quiet_time_reg <= cfg_data;
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            stage_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            stage_reg.req_type      <= req_type;
            stage_reg.now_us        <= now_us;
            stage_reg.frame_type    <= frame_type;
            stage_reg.frame_subtype <= frame_subtype;
            stage_reg.source_mac    <= source_mac;
        end
    end

    always_comb
    begin
        is_deauth = (stage_reg.frame_subtype == SUBTYPE_DEAUTH);
        counted   = (stage_reg.req_type == REQ_FRAME) &&
                    (stage_reg.frame_type == FTYPE_MGMT) &&
                    (is_deauth || (stage_reg.frame_subtype == SUBTYPE_DISASSOC));

        // A clock running backwards never expires the window nor counts as quiet.
        since_start = stage_reg.now_us - window_start_reg;
        expired     = (stage_reg.now_us >= window_start_reg) &&
                      (since_start > {{(TIME_W-CFG_W){1'b0}}, window_len_reg});
        since_flood = stage_reg.now_us - last_flood_reg;
        quiet       = (stage_reg.now_us >= last_flood_reg) &&
                      (since_flood > {{(TIME_W-CFG_W){1'b0}}, quiet_time_reg});

        new_window  = !window_open_reg || expired || (window_source_reg != stage_reg.source_mac);
        frames_base = new_window ? '0 : window_frames_reg;
        frames_inc  = (frames_base == COUNT_MAX) ? frames_base : frames_base + COUNT_W'(1);

        deauth_cnt_next    = deauth_cnt_reg;
        disassoc_cnt_next  = disassoc_cnt_reg;
        window_open_next   = window_open_reg;
        window_start_next  = window_start_reg;
        window_frames_next = window_frames_reg;
        window_source_next = window_source_reg;
        alert_flag_next    = alert_flag_reg;
        alert_mac_next     = alert_mac_reg;
        alert_rate_next    = alert_rate_reg;
        flood_seen_next    = flood_seen_reg;
        last_flood_next    = last_flood_reg;

        if (counted)
        begin
            if (is_deauth)
            begin
                deauth_cnt_next = deauth_cnt_reg + COUNT_W'(1);
            end
            else
            begin
                disassoc_cnt_next = disassoc_cnt_reg + COUNT_W'(1);
            end
            flood_seen_next    = 1'b1;
            last_flood_next    = stage_reg.now_us;
            window_open_next   = 1'b1;
            window_frames_next = frames_inc;
            if (new_window)
            begin
                window_start_next  = stage_reg.now_us;
                window_source_next = stage_reg.source_mac;
            end
            if (frames_inc >= {{(COUNT_W-THRESH_W){1'b0}}, threshold_reg})
            begin
                alert_flag_next = 1'b1;
                alert_mac_next  = stage_reg.source_mac;
                alert_rate_next = frames_inc;
            end
        end
        else if (stage_reg.req_type == REQ_POLL)
        begin
            if (alert_flag_reg && flood_seen_reg && quiet)
            begin
                alert_flag_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deauth_cnt_reg    <= '0;
            disassoc_cnt_reg  <= '0;
            window_open_reg   <= 1'b0;
            window_start_reg  <= '0;
            window_frames_reg <= '0;
            window_source_reg <= '0;
            alert_flag_reg    <= 1'b0;
            alert_mac_reg     <= '0;
            alert_rate_reg    <= '0;
            flood_seen_reg    <= 1'b0;
            last_flood_reg    <= '0;
        end
        else if (advance)
        begin
            deauth_cnt_reg    <= deauth_cnt_next;
            disassoc_cnt_reg  <= disassoc_cnt_next;
            window_open_reg   <= window_open_next;
            window_start_reg  <= window_start_next;
            window_frames_reg <= window_frames_next;
            window_source_reg <= window_source_next;
            alert_flag_reg    <= alert_flag_next;
            alert_mac_reg     <= alert_mac_next;
            alert_rate_reg    <= alert_rate_next;
            flood_seen_reg    <= flood_seen_next;
            last_flood_reg    <= last_flood_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= advance || (out_valid_reg && out_stall);
        end
    end

    // The state holds still while a result is stalled, so it drives the result beat directly.
    assign out_valid      = out_valid_reg;
    assign deauth_tally   = deauth_cnt_reg;
    assign disassoc_tally = disassoc_cnt_reg;
    assign alert_active   = alert_flag_reg;
    assign alert_source   = alert_mac_reg;
    assign alert_count    = alert_rate_reg;

    `ASSERT_SAME_CYCLE(a_stall_needs_full_out, clk, rst_n, in_stall, out_valid_reg && out_stall)
    `ASSERT_NEXT_CYCLE(a_advance_gives_result, clk, rst_n, advance, out_valid_reg)
    `ASSERT_SAME_CYCLE(a_alert_needs_flood, clk, rst_n, alert_flag_reg, flood_seen_reg)
    `ASSERT_SAME_CYCLE(a_window_has_frames, clk, rst_n, 1'b1,
        window_open_reg == (window_frames_reg != '0))
    `ASSERT_NEXT_CYCLE(a_state_holds_when_stalled, clk, rst_n, !advance,
        $stable(deauth_cnt_reg) && $stable(alert_flag_reg) && $stable(window_frames_reg))

endmodule
